>>> src/ils_pkg.sv
// Package for the indexed list store: sizes, command and status codes,
// and the command bundle broadcast to the row of storage cells.
// Used by every file of the block; depends on nothing.
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // read-back OR tree: fan-in of up to eight per level, four registered levels
  localparam int FAN    = 8;
  localparam int N1     = (CAPACITY + FAN - 1) / FAN;
  localparam int N2     = (N1 + FAN - 1) / FAN;
  localparam int N3     = (N2 + FAN - 1) / FAN;
  localparam int TREE_LAT = 4;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
  localparam logic [OP_W-1:0] OP_AT     = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic [WORD_W-1:0] MINUS_ONE = '1;

  typedef struct packed {
    logic              ins;    // shift up from point, write word at point
    logic              del;    // shift down from point
    logic [IDX_W-1:0]  point;
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

>>> src/indexed_list_store.sv
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit words
// held in a row of cells, with read, insert at head, tail or position, and
// delete at position. Each request yields one result with read data, status
// and the entry count after the request. Inserts and deletes shift every
// later cell at once, so for them and for out-of-range or unused requests
// the result is in the output register in the cycle after acceptance. An
// in-range read goes through the four-level registered OR tree before its
// entry reaches the output register. One request is in flight at a time;
// a new one is taken once the previous result has left or is leaving the
// output register. Depends on ils_pkg, ils_cell and ils_read_tree.
module indexed_list_store (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: [2:0] operation, [9:3] position, [41:10] value, [47:42] zero
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // m_tdata: [31:0] read_value, [33:32] status, [40:34] entry_count,
  //          [47:41] zero
  output logic [47:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                               state;
  logic [ils_pkg::CNT_W-1:0]          count;
  logic [ils_pkg::CNT_W-1:0]          count_next;
  logic [ils_pkg::WORD_W-1:0]         out_read;
  logic [ils_pkg::STAT_W-1:0]         out_status;
  logic [ils_pkg::ECNT_W-1:0]         out_count;
  logic [ils_pkg::STAT_W-1:0]         pend_status;
  logic [ils_pkg::ECNT_W-1:0]         pend_count;

  logic [ils_pkg::OP_W-1:0]           op;
  logic [ils_pkg::POS_W-1:0]          pos;
  logic [ils_pkg::WORD_W-1:0]         word;
  logic [ils_pkg::CMP_W-1:0]          pos_e;
  logic [ils_pkg::CMP_W-1:0]          cnt_e;
  logic                               accept;
  logic                               full;
  logic                               start_read;
  logic [ils_pkg::STAT_W-1:0]         status_next;
  logic [ils_pkg::WORD_W-1:0]         read_next;
  logic [ils_pkg::CNT_W+ils_pkg::ECNT_W-1:0] ecnt_wide;
  ils_pkg::cell_cmd_t                 cmd;

  logic [ils_pkg::WORD_W-1:0] cell_val [ils_pkg::CAPACITY];
  logic [ils_pkg::WORD_W-1:0] cell_rd  [ils_pkg::CAPACITY];
  logic                       tree_done;
  logic [ils_pkg::WORD_W-1:0] tree_result;

  assign op   = s_tdata[2:0];
  assign pos  = s_tdata[9:3];
  assign word = s_tdata[41:10];

  assign pos_e = ils_pkg::CMP_W'(pos);
  assign cnt_e = ils_pkg::CMP_W'(count);
  assign full  = (count == ils_pkg::CNT_W'(ils_pkg::CAPACITY));

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd         = '0;
    cmd.word    = word;
    count_next  = count;
    status_next = ils_pkg::STAT_DONE;
    read_next   = '0;
    start_read  = 1'b0;
    case (op)
      ils_pkg::OP_READ: begin
        if (pos_e < cnt_e) begin
          start_read = 1'b1;
        end else begin
          read_next   = ils_pkg::MINUS_ONE;
          status_next = ils_pkg::STAT_RANGE;
        end
      end
      ils_pkg::OP_HEAD, ils_pkg::OP_TAIL, ils_pkg::OP_AT: begin
        if (op == ils_pkg::OP_HEAD) begin
          cmd.point = '0;
        end else if (op == ils_pkg::OP_TAIL) begin
          cmd.point = count[ils_pkg::IDX_W-1:0];
        end else begin
          cmd.point = pos_e[ils_pkg::IDX_W-1:0];
        end
        // position check first, then capacity
        if ((op == ils_pkg::OP_AT) && (pos_e > cnt_e)) begin
          status_next = ils_pkg::STAT_RANGE;
        end else if (full) begin
          status_next = ils_pkg::STAT_FULL;
        end else begin
          cmd.ins    = accept;
          count_next = count + ils_pkg::CNT_W'(1);
        end
      end
      ils_pkg::OP_DELETE: begin
        cmd.point = pos_e[ils_pkg::IDX_W-1:0];
        if (pos_e < cnt_e) begin
          cmd.del    = accept;
          count_next = count - ils_pkg::CNT_W'(1);
        end else begin
          status_next = ils_pkg::STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // entry_count reports the count modulo 128
  assign ecnt_wide = {{ils_pkg::ECNT_W{1'b0}}, count_next};

  for (genvar i = 0; i < ils_pkg::CAPACITY; i++) begin : g_cell
    logic [ils_pkg::WORD_W-1:0] left_val;
    logic [ils_pkg::WORD_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == ils_pkg::CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end
    ils_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .my_index  (ils_pkg::IDX_W'(i)),
      .left_val  (left_val),
      .right_val (right_val),
      .read_pos  (pos_e[ils_pkg::IDX_W-1:0]),
      .val       (cell_val[i]),
      .rd_masked (cell_rd[i])
    );
  end

  ils_read_tree u_tree (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && start_read),
    .leaf   (cell_rd),
    .done   (tree_done),
    .result (tree_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (start_read) begin
              state <= S_READ;
            end else begin
              m_tvalid <= 1'b1;
            end
          end
        end
        S_READ: begin
          // hold until the tree hands back the addressed entry
          if (tree_done) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read    <= read_next;
      out_status  <= status_next;
      out_count   <= ecnt_wide[ils_pkg::ECNT_W-1:0];
      pend_status <= status_next;
      pend_count  <= ecnt_wide[ils_pkg::ECNT_W-1:0];
    end else if ((state == S_READ) && tree_done) begin
      out_read   <= tree_result;
      out_status <= pend_status;
      out_count  <= pend_count;
    end
  end

  assign m_tdata = {7'b0, out_count, out_status, out_read};

endmodule

>>> src/ils_cell.sv
// One storage cell of the list: holds a single entry and trades it with
// its neighbors on insert and delete. Depends on ils_pkg.
module ils_cell (
  input  logic                       clk,
  input  ils_pkg::cell_cmd_t         cmd,
  input  logic [ils_pkg::IDX_W-1:0]  my_index,
  input  logic [ils_pkg::WORD_W-1:0] left_val,
  input  logic [ils_pkg::WORD_W-1:0] right_val,
  input  logic [ils_pkg::IDX_W-1:0]  read_pos,
  output logic [ils_pkg::WORD_W-1:0] val,
  output logic [ils_pkg::WORD_W-1:0] rd_masked
);

  logic [ils_pkg::WORD_W-1:0] val_next;

  always_comb begin
    val_next = val;
    if (cmd.ins) begin
      if (my_index > cmd.point) begin
        val_next = left_val;
      end else if (my_index == cmd.point) begin
        val_next = cmd.word;
      end
    end else if (cmd.del) begin
      if (my_index >= cmd.point) begin
        val_next = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  // drive the entry onto the read tree only when addressed
  assign rd_masked = (my_index == read_pos) ? val : '0;

endmodule

>>> src/ils_read_tree.sv
// Registered OR tree that collects the one addressed cell's entry.
// Four levels of fan-in up to eight; depends on ils_pkg.
module ils_read_tree (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ils_pkg::WORD_W-1:0] leaf [ils_pkg::CAPACITY],
  output logic                       done,
  output logic [ils_pkg::WORD_W-1:0] result
);

  logic [ils_pkg::WORD_W-1:0] lvl1 [ils_pkg::N1];
  logic [ils_pkg::WORD_W-1:0] lvl2 [ils_pkg::N2];
  logic [ils_pkg::WORD_W-1:0] lvl3 [ils_pkg::N3];
  logic [ils_pkg::WORD_W-1:0] lvl1_next [ils_pkg::N1];
  logic [ils_pkg::WORD_W-1:0] lvl2_next [ils_pkg::N2];
  logic [ils_pkg::WORD_W-1:0] lvl3_next [ils_pkg::N3];
  logic [ils_pkg::WORD_W-1:0] result_next;
  logic [ils_pkg::TREE_LAT-1:0] busy;

  always_comb begin
    for (int g = 0; g < ils_pkg::N1; g++) begin
      lvl1_next[g] = '0;
      for (int k = 0; k < ils_pkg::FAN; k++) begin
        if (g * ils_pkg::FAN + k < ils_pkg::CAPACITY) begin
          lvl1_next[g] = lvl1_next[g] | leaf[g * ils_pkg::FAN + k];
        end
      end
    end
    for (int g = 0; g < ils_pkg::N2; g++) begin
      lvl2_next[g] = '0;
      for (int k = 0; k < ils_pkg::FAN; k++) begin
        if (g * ils_pkg::FAN + k < ils_pkg::N1) begin
          lvl2_next[g] = lvl2_next[g] | lvl1[g * ils_pkg::FAN + k];
        end
      end
    end
    for (int g = 0; g < ils_pkg::N3; g++) begin
      lvl3_next[g] = '0;
      for (int k = 0; k < ils_pkg::FAN; k++) begin
        if (g * ils_pkg::FAN + k < ils_pkg::N2) begin
          lvl3_next[g] = lvl3_next[g] | lvl2[g * ils_pkg::FAN + k];
        end
      end
    end
    result_next = '0;
    for (int g = 0; g < ils_pkg::N3; g++) begin
      result_next = result_next | lvl3[g];
    end
  end

  always_ff @(posedge clk) begin
    lvl1   <= lvl1_next;
    lvl2   <= lvl2_next;
    lvl3   <= lvl3_next;
    result <= result_next;
  end

  // track the request through the levels
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      busy <= {busy[ils_pkg::TREE_LAT-2:0], start};
    end
  end

  assign done = busy[ils_pkg::TREE_LAT-1];

endmodule
